@@ hdl/stp_pkg.sv @@
package stp_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_SUFFIX = 2'd3;

  // Sign codes
  localparam logic [1:0] SG_SET   = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;

  // Characters of the grammar
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_K = 8'h6B;
  localparam logic [7:0] CH_LOW_M = 8'h6D;
  localparam logic [7:0] CH_LOW_G = 8'h67;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam int ACC_W  = 64;
  localparam int SIZE_W = 63;

  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       sign_mode;
    logic [ACC_W-1:0] acc;
    logic             invalid;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:     PH_FIRST,
    sign_mode: SG_SET,
    acc:       '0,
    invalid:   1'b0
  };

endpackage

@@ hdl/stp_char_step.sv @@
module stp_char_step
  import stp_pkg::*;
(
  input  logic [7:0]   chr,
  input  parse_state_t cur_st,
  output parse_state_t next_st
);

  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W-1:0] base;
  logic [ACC_W+3:0] mac;
  logic             mac_ovf;
  logic [7:0]       folded;
  logic             sfx_k;
  logic             sfx_m;
  logic             sfx_g;

  assign is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
  assign digit    = 4'(chr - CH_ZERO);
  // A first digit starts from zero
  assign base     = (cur_st.phase == PH_DIGITS) ? cur_st.acc : '0;
  // acc * 10 + d as two shifts and two adds
  assign mac      = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {{ACC_W{1'b0}}, digit};
  assign mac_ovf  = |mac[ACC_W+3:ACC_W];

  assign folded = chr | CASE_BIT;
  assign sfx_k  = (folded == CH_LOW_K);
  assign sfx_m  = (folded == CH_LOW_M);
  assign sfx_g  = (folded == CH_LOW_G);

  always_comb begin
    next_st = cur_st;
    if (!cur_st.invalid) begin
      case (cur_st.phase)
        PH_FIRST: begin
          if (chr == CH_PLUS) begin
            next_st.sign_mode = SG_PLUS;
            next_st.phase     = PH_SIGNED;
          end else if (chr == CH_MINUS) begin
            next_st.sign_mode = SG_MINUS;
            next_st.phase     = PH_SIGNED;
          end else if (is_digit) begin
            next_st.acc   = mac[ACC_W-1:0];
            next_st.phase = PH_DIGITS;
          end else begin
            next_st.invalid = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (is_digit) begin
            next_st.acc   = mac[ACC_W-1:0];
            next_st.phase = PH_DIGITS;
          end else begin
            next_st.invalid = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (mac_ovf) begin
              next_st.invalid = 1'b1;
            end else begin
              next_st.acc = mac[ACC_W-1:0];
            end
          end else if (sfx_k) begin
            if (|cur_st.acc[ACC_W-1:ACC_W-10]) begin
              next_st.invalid = 1'b1;
            end else begin
              next_st.acc   = {cur_st.acc[ACC_W-11:0], 10'd0};
              next_st.phase = PH_SUFFIX;
            end
          end else if (sfx_m) begin
            if (|cur_st.acc[ACC_W-1:ACC_W-20]) begin
              next_st.invalid = 1'b1;
            end else begin
              next_st.acc   = {cur_st.acc[ACC_W-21:0], 20'd0};
              next_st.phase = PH_SUFFIX;
            end
          end else if (sfx_g) begin
            if (|cur_st.acc[ACC_W-1:ACC_W-30]) begin
              next_st.invalid = 1'b1;
            end else begin
              next_st.acc   = {cur_st.acc[ACC_W-31:0], 30'd0};
              next_st.phase = PH_SUFFIX;
            end
          end else begin
            next_st.invalid = 1'b1;
          end
        end
        default: begin
          next_st.invalid = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ hdl/stp_resolve.sv @@
module stp_resolve
  import stp_pkg::*;
(
  input  parse_state_t      fin_st,
  input  logic [SIZE_W-1:0] cur_size,
  output logic              bad,
  output logic [SIZE_W-1:0] size_out
);

  logic [SIZE_W:0]   sum;
  logic [SIZE_W:0]   diff;
  logic              parse_bad;
  logic [SIZE_W-1:0] res;

  assign parse_bad = fin_st.invalid
                   || ((fin_st.phase != PH_DIGITS) && (fin_st.phase != PH_SUFFIX))
                   || fin_st.acc[ACC_W-1];
  assign sum  = {1'b0, cur_size} + {1'b0, fin_st.acc[SIZE_W-1:0]};
  assign diff = {1'b0, cur_size} - {1'b0, fin_st.acc[SIZE_W-1:0]};

  always_comb begin
    bad = parse_bad;
    res = fin_st.acc[SIZE_W-1:0];
    case (fin_st.sign_mode)
      SG_PLUS: begin
        res = sum[SIZE_W-1:0];
        if (sum[SIZE_W]) begin
          bad = 1'b1;
        end
      end
      SG_MINUS: begin
        // Floor at zero when the value exceeds the current size
        res = diff[SIZE_W] ? '0 : diff[SIZE_W-1:0];
      end
      default: begin
        res = fin_st.acc[SIZE_W-1:0];
      end
    endcase
    size_out = bad ? '0 : res;
  end

endmodule

@@ hdl/size_text_parser.sv @@
// Channel  Handshake             Payload
// -------  --------------------  ---------------------------------------
// input    in_valid / in_ready   chr[7:0], is_last, current_size[62:0]
// output   out_valid / out_ready status, new_size[62:0]
//
// One character per cycle unless the input stalls; the character step
// (multiply-by-ten add or suffix shift) updates the parse state from the input
// register. A last character then passes the final and result registers
// before out_valid rises. Reset (rst, synchronous) empties all stages and
// clears the parse state. Only a last character waits for room downstream:
// the input stalls while one sits in the input register, both later stages
// are full and out_ready is low.
module size_text_parser
  import stp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        chr,
  input  logic              is_last,
  input  logic [SIZE_W-1:0] current_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [SIZE_W-1:0] new_size
);

  // Input register
  logic              r_v;
  logic [7:0]        r_chr;
  logic              r_last;
  logic [SIZE_W-1:0] r_cur;

  // Parse state, carried from character to character
  parse_state_t      st;
  parse_state_t      st_next;

  // Final register: parse state after the last character plus its size
  logic              f_v;
  parse_state_t      fin;
  logic [SIZE_W-1:0] f_cur;

  // Result register
  logic              o_v;
  logic              o_status;
  logic [SIZE_W-1:0] o_size;

  logic              o_free;
  logic              f_free;
  logic              r_go;
  logic              res_bad;
  logic [SIZE_W-1:0] res_size;

  // Advance each stage when the one after it can take its contents
  assign o_free   = !o_v || out_ready;
  assign f_free   = !f_v || o_free;
  // Only a last character needs room downstream
  assign r_go     = r_v && (!r_last || f_free);
  assign in_ready = !r_v || r_go;

  stp_char_step u_step (
    .chr     (r_chr),
    .cur_st  (st),
    .next_st (st_next)
  );

  stp_resolve u_resolve (
    .fin_st   (fin),
    .cur_size (f_cur),
    .bad      (res_bad),
    .size_out (res_size)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (in_ready) begin
      r_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      r_chr  <= chr;
      r_last <= is_last;
      r_cur  <= current_size;
    end
  end

  // Step the parse state; clear it once the last character has gone through
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else if (r_go) begin
      st <= r_last ? PARSE_RESET : st_next;
    end
  end

  // Final stage: hold the finished parse for the sign arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (f_free) begin
      f_v <= r_go && r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (f_free && r_go && r_last) begin
      fin   <= st_next;
      f_cur <= r_cur;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_free) begin
      o_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && f_v) begin
      o_status <= res_bad;
      o_size   <= res_size;
    end
  end

  assign out_valid = o_v;
  assign status    = o_status;
  assign new_size  = o_size;

  // A last character leaves the parser back at its start
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (r_go && r_last) |=> (st.phase == PH_FIRST && st.sign_mode == SG_SET && !st.invalid))
    else $error("parse state not cleared after last character");

  // An invalid result carries a zero size
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (new_size == '0))
    else $error("invalid result with nonzero size");

  // A blocked input means a character is waiting in the input register
  a_ready_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (r_v && r_last && f_v && o_v && !out_ready))
    else $error("input stalled without a full pipeline");

  // The final stage holds while the result register is stalled
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (f_v && !o_free) |=> (f_v && $stable(fin) && $stable(f_cur)))
    else $error("final stage changed under stall");

endmodule

@@ tb/size_text_parser_test.sv @@
module size_text_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  // Give up well past the slowest legal run: ~1000 requests, each with idle
  // gaps on either side, the pipeline latency and one long hold-off.
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int TEXT_CHARS  = 950;
  localparam logic [SIZE_W-1:0] MAX_SIZE = '1;

  typedef logic [7:0] text_t[$];

  // Keeps a cycle-true copy of the parse state, predicts the size that each
  // last character yields and matches it against what the block returns.
  class size_checker;
    localparam logic [ACC_W-1:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] RADIX = 64'd10;
    localparam logic [ACC_W-1:0] KILO  = 64'd1024;

    typedef struct packed {
      logic              status;
      logic [SIZE_W-1:0] size;
    } size_result_t;

    logic [1:0]       phase_q;
    logic [1:0]       sign_q;
    logic [ACC_W-1:0] value_q;
    logic             bad_text_q;
    size_result_t     expected_sizes[$];
    int               failures;

    function new();
      clear();
      failures = 0;
    endfunction

    function void clear();
      phase_q    = PH_FIRST;
      sign_q     = SG_SET;
      value_q    = '0;
      bad_text_q = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Multiply by ten and add, flagging a carry past 64 bits.
    function void push_digit(logic [7:0] c);
      logic [ACC_W-1:0] d;
      d = ACC_W'(c - CH_ZERO);
      if (value_q > (MAX64 - d) / RADIX) begin
        bad_text_q = 1'b1;
      end else begin
        value_q = value_q * RADIX + d;
      end
    endfunction

    function void note_request(logic [7:0] c, logic last, logic [SIZE_W-1:0] cur);
      logic [ACC_W-1:0] scale;
      logic [ACC_W-1:0] base;
      logic [ACC_W-1:0] res;
      logic             bad;
      size_result_t     r;
      if (!bad_text_q) begin
        case (phase_q)
          PH_FIRST: begin
            if (c == CH_PLUS) begin
              sign_q  = SG_PLUS;
              phase_q = PH_SIGNED;
            end else if (c == CH_MINUS) begin
              sign_q  = SG_MINUS;
              phase_q = PH_SIGNED;
            end else if (is_digit(c)) begin
              value_q = '0;
              push_digit(c);
              phase_q = PH_DIGITS;
            end else begin
              bad_text_q = 1'b1;
            end
          end
          PH_SIGNED: begin
            if (is_digit(c)) begin
              value_q = '0;
              push_digit(c);
              phase_q = PH_DIGITS;
            end else begin
              bad_text_q = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_digit(c)) begin
              push_digit(c);
            end else begin
              case (c | CASE_BIT)
                CH_LOW_K: scale = KILO;
                CH_LOW_M: scale = KILO * KILO;
                CH_LOW_G: scale = KILO * KILO * KILO;
                default:  scale = '0;
              endcase
              if (scale == '0 || value_q > MAX64 / scale) begin
                bad_text_q = 1'b1;
              end else begin
                value_q = value_q * scale;
                phase_q = PH_SUFFIX;
              end
            end
          end
          default: bad_text_q = 1'b1;
        endcase
      end
      if (!last) return;

      base = {1'b0, cur};
      res  = '0;
      bad  = bad_text_q || (phase_q != PH_DIGITS && phase_q != PH_SUFFIX);
      if (!bad && value_q > MAX63) bad = 1'b1;
      if (!bad) begin
        case (sign_q)
          SG_PLUS: begin
            if (value_q > MAX63 - base) bad = 1'b1;
            else res = base + value_q;
          end
          SG_MINUS: res = (value_q > base) ? '0 : base - value_q;
          default:  res = value_q;
        endcase
      end
      r.status = bad;
      r.size   = bad ? '0 : res[SIZE_W-1:0];
      expected_sizes.push_back(r);
      clear();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    function void check_result(logic status, logic [SIZE_W-1:0] size);
      size_result_t r;
      if (expected_sizes.size() == 0) begin
        flag($sformatf("unexpected result: status %0b size %0d", status, size));
        return;
      end
      r = expected_sizes.pop_front();
      if (status !== r.status || size !== r.size) begin
        flag($sformatf("size mismatch: expected status %0b size %0d, got status %0b size %0d",
                       r.status, r.size, status, size));
      end
    endfunction

    function int pending();
      return expected_sizes.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        chr;
  logic              is_last;
  logic [SIZE_W-1:0] current_size;
  logic              out_valid;
  logic              out_ready;
  logic              status;
  logic [SIZE_W-1:0] new_size;

  size_checker sb;
  int          cycle_count = 0;
  int          sent_chars  = 0;
  bit          steady_tx   = 1'b0;  // sender offers back to back
  bit          steady_rx   = 1'b0;  // receiver takes back to back
  bit          hold_request = 1'b0; // ask the receiver for one long hold-off

  size_text_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .chr          (chr),
    .is_last      (is_last),
    .current_size (current_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .new_size     (new_size)
  );

  always #2 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample both handshakes at the edge where they complete. The request side
  // goes first; a result trails its last character through the input, final and result registers.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(chr, is_last, current_size);
      if (out_valid && out_ready) sb.check_result(status, new_size);
    end
  end

  function automatic logic [SIZE_W-1:0] rand_size();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SIZE_W-1:0];
  endfunction

  // Pick one of K, M, G in either case.
  function automatic logic [7:0] random_suffix();
    logic [7:0] s;
    case ($urandom_range(0, 2))
      0:       s = CH_LOW_K;
      1:       s = CH_LOW_M;
      default: s = CH_LOW_G;
    endcase
    return $urandom_range(0, 1) ? s ^ CASE_BIT : s;
  endfunction

  // Any character that has a meaning somewhere in the grammar.
  function automatic logic [7:0] grammar_char();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_ZERO + 8'($urandom_range(0, 9));
      default: return random_suffix();
    endcase
  endfunction

  // Offer one character. Idle first if drawn, then hold valid and payload
  // until the block takes the request.
  task automatic send_char(input logic [7:0] c, input logic last,
                           input logic [SIZE_W-1:0] cur);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    chr          <= c;
    is_last      <= last;
    current_size <= cur;
    do @(posedge clk); while (!in_ready);
    sent_chars++;
  endtask

  // Send a whole size text; only its last character carries a meaningful size.
  task automatic send_text(input text_t txt, input logic [SIZE_W-1:0] cur);
    for (int i = 0; i < txt.size(); i++) begin
      send_char(txt[i], i == txt.size() - 1, (i == txt.size() - 1) ? cur : rand_size());
    end
  endtask

  task automatic send_str(input string s, input logic [SIZE_W-1:0] cur);
    text_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_text(txt, cur);
  endtask

  // Receiver: draw a stall before each result, honor a long hold-off when
  // asked, and count it here so the sender keeps pushing meanwhile.
  initial begin
    int gap;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = steady_rx ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    text_t            txt;
    string            digits;
    logic [63:0]      val;
    logic [SIZE_W-1:0] cur;
    int               kind;
    int               pos;
    int               base;
    int               texts;

    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    chr          = '0;
    is_last      = 1'b0;
    current_size = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: field extremes, both signs, the saturating and
    // overflowing ends, and the malformed shapes.
    send_str("0", MAX_SIZE);
    send_str("9", '0);
    send_str("+5", MAX_SIZE);          // plus overflows
    send_str("+5", MAX_SIZE - 63'd5);  // plus fits exactly
    send_str("-7", 63'd3);             // minus floors at zero
    send_str("-3", MAX_SIZE);
    send_str("+", 63'd5);              // sign with no digits
    send_str("8G", '0);
    send_str("1kx", '0);               // character after suffix
    send_str("--1", '0);               // second sign
    send_str("1+", '0);                // sign after a digit
    txt.delete();
    txt.push_back(8'h00);              // NUL byte
    send_text(txt, '0);
    txt.delete();
    txt.push_back(CH_ZERO + 8'd5);
    txt.push_back(8'hFF);
    send_text(txt, MAX_SIZE);

    // Random texts: mostly well-formed with random content, some broken,
    // some pure noise.
    base  = sent_chars;
    texts = 0;
    while (sent_chars - base < TEXT_CHARS) begin
      // Switch the idling pattern now and then so back-to-back stretches occur.
      if (texts % 40 == 0) begin
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
      end
      // Stall the output for a long stretch while requests keep coming.
      if (texts == 150) begin
        steady_tx    = 1'b1;
        hold_request = 1'b1;
      end
      texts++;

      txt.delete();
      case ($urandom_range(0, 2))
        1:       txt.push_back(CH_PLUS);
        2:       txt.push_back(CH_MINUS);
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: val = 64'($urandom_range(0, 999));
        4, 5:       val = 64'($urandom);
        6, 7, 8:    val = {$urandom, $urandom} >> $urandom_range(0, 40);
        default: begin
          case ($urandom_range(0, 4))
            0:       val = 64'h7FFF_FFFF_FFFF_FFFF;
            1:       val = 64'h8000_0000_0000_0000;
            2:       val = '1;
            3:       val = '0;
            default: val = 64'd8589934592;  // reaches 2^63 with a G suffix
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0) txt.push_back(CH_ZERO);
      digits = $sformatf("%0d", val);
      for (int i = 0; i < digits.len(); i++) txt.push_back(digits[i]);
      // Extra digits can push a value past 64 bits.
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 2) == 0) txt.push_back(random_suffix());

      case ($urandom_range(0, 5))
        0:       cur = '0;
        1:       cur = MAX_SIZE;
        2:       cur = rand_size();
        3:       cur = val[SIZE_W-1:0];
        4:       cur = MAX_SIZE - val[SIZE_W-1:0];
        default: cur = SIZE_W'($urandom_range(0, 4095));
      endcase

      kind = $urandom_range(0, 9);
      if (kind == 7 || kind == 8) begin
        // Break the text: overwrite, insert, append, or strip the digits.
        case ($urandom_range(0, 3))
          0: begin
            pos      = $urandom_range(0, txt.size() - 1);
            txt[pos] = 8'($urandom);
          end
          1: begin
            pos = $urandom_range(0, txt.size());
            txt.insert(pos, grammar_char());
          end
          2: txt.push_back(grammar_char());
          default: begin
            txt.delete();
            if ($urandom_range(0, 1)) txt.push_back(CH_PLUS);
            txt.push_back($urandom_range(0, 1) ? random_suffix() : CH_MINUS);
          end
        endcase
      end else if (kind == 9) begin
        txt.delete();
        repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom));
      end
      send_text(txt, cur);
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding size, then keep watching for stray
    // results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
